[design/tsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEO_MODE     = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PADDED_WIDTH = 2'd1;

	localparam int WIDTH_BITS  = 15;
	localparam int OFFSET_BITS = 32;
	localparam logic [WIDTH_BITS-1:0] PADDED_WIDTH_RESET = 15'd1920;

	// Macro tiles are 128 pixels wide; rows per macro tile depend on mode
	localparam int MACRO_X_SHIFT     = 7;
	localparam int MACRO_Y_SHIFT     = 6;
	localparam int MACRO_Y_SHIFT_NEO = 7;

	// Coordinates are widened to this for the swizzle functions
	localparam int SWZ_BITS = 16;

	typedef logic [SWZ_BITS-1:0] swz_coord_t;

	// Byte offset within the micro tile (element index times four)
	function automatic logic [7:0] elem_bytes(input swz_coord_t x, input swz_coord_t y);
		return {y[2], y[1], x[2], y[0], x[1], x[0], 2'b00};
	endfunction

	// Pipe and bank bits packed as they land in offset bits 14:8
	function automatic logic [6:0] pipe_bank(input swz_coord_t x, input swz_coord_t y,
			input logic neo);
		logic [3:0] pipe;
		logic [3:0] bank;
		pipe[0] = x[3] ^ y[3] ^ x[4];
		pipe[1] = x[4] ^ y[4];
		pipe[2] = x[5] ^ y[5];
		pipe[3] = x[6] ^ y[5];
		if (neo) begin
			bank[0] = x[7] ^ y[6];
			bank[1] = x[8] ^ y[5] ^ y[6];
			bank[2] = x[9] ^ y[4];
			bank[3] = 1'b0;
			return {bank[2:0], pipe[3:0]};
		end else begin
			bank[0] = x[6] ^ y[6];
			bank[1] = x[7] ^ y[5] ^ y[6];
			bank[2] = x[8] ^ y[4];
			bank[3] = x[9] ^ y[3];
			return {bank[3:0], pipe[2:0]};
		end
	endfunction

endpackage

`default_nettype wire

[design/tiled_surface_address_top.sv]
// Tiled surface address generator, 32 bits per pixel, 2D thin macro tiling.
// Input channel: in_valid/in_ready with pixel_x and pixel_y. Output channel:
// out_valid/out_ready with byte_offset, the byte offset of the pixel.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is neo_mode (bit 0), index 1 is padded_width (bits 14:0), other
// indexes are ignored. cfg_ready is always high; write only while idle.
// From input acceptance to out_valid a word passes one input register,
// then the swizzle, a narrow row-by-width multiply and an add into the
// result register. Throughput is one word per clock while the receiver
// takes results, set by the two-register pipeline with no iterating unit.
// When the receiver stalls the result register holds; the input register
// still takes a word while it is empty, and in_ready drops only when both
// hold a word. in_ready follows out_ready within the same cycle.
// Reset empties both stages and sets neo_mode to 0 and padded_width to 1920.
`timescale 1ns / 1ps
`default_nettype none

module tiled_surface_address_top #(
	parameter int COORD_BITS = 14
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [COORD_BITS-1:0]                pixel_x,
	input  wire  [COORD_BITS-1:0]                pixel_y,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [tsa_pkg::OFFSET_BITS-1:0]      byte_offset,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [tsa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire  [tsa_pkg::WIDTH_BITS-1:0]       cfg_data
);

	localparam int ROW_BITS = COORD_BITS - tsa_pkg::MACRO_Y_SHIFT;
	localparam int PER_ROW_BITS = tsa_pkg::WIDTH_BITS - tsa_pkg::MACRO_X_SHIFT;
	localparam int MT_BITS = ROW_BITS + PER_ROW_BITS + 1;

	logic                              neo_mode_q;
	logic [tsa_pkg::WIDTH_BITS-1:0]    padded_width_q;

	logic                              valid_s1;
	logic [COORD_BITS-1:0]             x_s1;
	logic [COORD_BITS-1:0]             y_s1;
	logic                              valid_s2;
	logic [tsa_pkg::OFFSET_BITS-1:0]   offset_s2;

	logic                              adv_s2;
	logic                              move_s1;

	tsa_pkg::swz_coord_t               x_w;
	tsa_pkg::swz_coord_t               y_w;
	logic [PER_ROW_BITS-1:0]           per_row;
	logic [ROW_BITS-1:0]               mt_row;
	logic [ROW_BITS+PER_ROW_BITS-1:0]  row_base;
	logic [MT_BITS-1:0]                mt_index;
	logic [tsa_pkg::OFFSET_BITS-1:0]   upper;
	logic [tsa_pkg::OFFSET_BITS-1:0]   offset_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neo_mode_q     <= 1'b0;
			padded_width_q <= tsa_pkg::PADDED_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsa_pkg::REG_NEO_MODE:     neo_mode_q <= cfg_data[0];
				tsa_pkg::REG_PADDED_WIDTH: padded_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Result register frees when empty or taken; input register when empty or it moves on
	assign adv_s2   = !valid_s2 || out_ready;
	assign move_s1  = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
		if (move_s1) begin
			offset_s2 <= offset_d;
		end
	end

	always_comb begin
		x_w      = tsa_pkg::SWZ_BITS'(x_s1);
		y_w      = tsa_pkg::SWZ_BITS'(y_s1);
		per_row  = padded_width_q[tsa_pkg::WIDTH_BITS-1:tsa_pkg::MACRO_X_SHIFT];
		mt_row   = neo_mode_q ? ROW_BITS'(y_s1 >> tsa_pkg::MACRO_Y_SHIFT_NEO)
		                      : ROW_BITS'(y_s1 >> tsa_pkg::MACRO_Y_SHIFT);
		row_base = mt_row * per_row;
		mt_index = MT_BITS'(row_base) + MT_BITS'(x_s1 >> tsa_pkg::MACRO_X_SHIFT);
		// Offset from bit 15 up: macro tile index in 32768-byte units, two tiles per
		// macro tile in neo mode with y bit 3 choosing the tile
		upper    = neo_mode_q ? (tsa_pkg::OFFSET_BITS'(mt_index) << 1) |
		                        tsa_pkg::OFFSET_BITS'(y_s1[3])
		                      : tsa_pkg::OFFSET_BITS'(mt_index);
		offset_d = {upper[16:0], tsa_pkg::pipe_bank(x_w, y_w, neo_mode_q),
		            tsa_pkg::elem_bytes(x_w, y_w)};
	end

	assign out_valid   = valid_s2;
	assign byte_offset = offset_s2;

`ifndef SYNTHESIS
	a_in_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_move_fills_s2 : assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> out_valid)
		else $error("word leaving the input register did not reach the output");

	a_word_aligned : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_offset[1:0] == 2'b00)
		else $error("offset not on a pixel boundary");

	a_neo_write : assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == tsa_pkg::REG_NEO_MODE |=> neo_mode_q == $past(cfg_data[0]))
		else $error("mode register write lost");
`endif

endmodule

`default_nettype wire
